// File: rtl/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg
// Shared widths, constants, command codes and the controller-to-datapath
// command struct of the gain-scheduled PD steering block.
// ----------------------------------------------------------------------------
package gps_pkg;

	localparam int ERR_W   = 12;   // position error
	localparam int SPD_W   = 13;   // average speed
	localparam int GAIN_W  = 32;   // Q16.16 gains
	localparam int OUT_W   = 16;   // Q8.8 steering output
	localparam int IDX_W   = 2;    // config register index
	localparam int DIFF_W  = ERR_W + 1;
	localparam int SCHED_W = 12;   // schedule, unsigned Q4.8, 0..2560
	localparam int KSTEP_W = 22;   // schedule times 576
	localparam int KD_W    = GAIN_W + 1;
	localparam int MA_W    = 2 * ERR_W - 1;   // err times abs err
	localparam int MB_W    = KD_W;
	localparam int MP_W    = MA_W + MB_W;
	localparam int ACC_W   = MP_W + 1;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_GAIN_PROP  = 2'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_QUAD  = 2'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_DERIV = 2'd2;

	// Schedule: floor(n*16/5), clamped to 10.0 once n reaches 800
	localparam int                 SCHED_KNEE = 800;
	localparam logic [SCHED_W-1:0] SCHED_MAX  = 12'd2560;
	localparam logic [13:0]        RECIP_5    = 14'd13108;   // 2^16/5, rounded up

	localparam int OUT_LIMIT = 25600;
	localparam int SUM_LIMIT = OUT_LIMIT * 256;

	typedef enum logic [1:0] {
		MUL_PROP,
		MUL_EAE,
		MUL_QUAD,
		MUL_DERIV
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		logic     load_in;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     load_out;
	} dp_cmd_t;

endpackage

// File: rtl/gps_dp.sv
// ----------------------------------------------------------------------------
// gps_dp
// Datapath: gain registers, previous error, schedule and derivative gain,
// one shared signed multiplier, the accumulator and output saturation.
// ----------------------------------------------------------------------------
module gps_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gps_pkg::IDX_W-1:0]         cfg_index,
	input  logic [gps_pkg::GAIN_W-1:0]        cfg_data,
	input  logic signed [gps_pkg::ERR_W-1:0]  pos_error,
	input  logic signed [gps_pkg::SPD_W-1:0]  avg_speed,
	input  gps_pkg::dp_cmd_t                  cmd,
	output logic signed [gps_pkg::OUT_W-1:0]  steer_out
);

	logic signed [gps_pkg::GAIN_W-1:0]  gain_prop_q;
	logic signed [gps_pkg::GAIN_W-1:0]  gain_quad_q;
	logic signed [gps_pkg::GAIN_W-1:0]  gain_deriv_q;
	logic signed [gps_pkg::ERR_W-1:0]   prev_error_q;

	logic signed [gps_pkg::ERR_W-1:0]   e_q;
	logic signed [gps_pkg::SPD_W-1:0]   spd_q;
	logic signed [gps_pkg::DIFF_W-1:0]  diff_q;
	logic [gps_pkg::SCHED_W-1:0]        sched_q;
	logic signed [gps_pkg::KD_W-1:0]    kd_q;
	logic signed [gps_pkg::MP_W-1:0]    prod_q;
	logic signed [gps_pkg::ACC_W-1:0]   acc_q;
	logic signed [gps_pkg::OUT_W-1:0]   steer_q;

	logic [gps_pkg::ERR_W-1:0]          ae;
	logic signed [14:0]                 n;
	logic [13:0]                        x16;
	logic [27:0]                        rprod;
	logic [gps_pkg::SCHED_W-1:0]        sched;
	logic [gps_pkg::KSTEP_W-1:0]        kstep;
	logic signed [gps_pkg::MA_W-1:0]    mul_a;
	logic signed [gps_pkg::MB_W-1:0]    mul_b;
	logic signed [gps_pkg::MP_W-1:0]    mul_p;
	logic signed [gps_pkg::OUT_W-1:0]   steer;

	// Configuration and previous error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= '0;
			gain_quad_q  <= '0;
			gain_deriv_q <= '0;
			prev_error_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gps_pkg::REG_GAIN_PROP:  gain_prop_q  <= cfg_data;
					gps_pkg::REG_GAIN_QUAD:  gain_quad_q  <= cfg_data;
					gps_pkg::REG_GAIN_DERIV: gain_deriv_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load_in) begin
				prev_error_q <= pos_error;
			end
		end
	end

	// Schedule from the held item
	always_comb begin
		ae    = e_q[gps_pkg::ERR_W-1] ? gps_pkg::ERR_W'(-e_q) : e_q;
		n     = $signed({1'b0, ae, 2'b00}) + 15'(spd_q);
		x16   = {n[9:0], 4'b0000};
		rprod = x16 * gps_pkg::RECIP_5;
		if (n <= 15'sd0) begin
			sched = '0;
		end else if (n >= 15'(gps_pkg::SCHED_KNEE)) begin
			sched = gps_pkg::SCHED_MAX;
		end else begin
			sched = rprod[27:16];
		end
		// 576 = 512 + 64
		kstep = gps_pkg::KSTEP_W'({sched_q, 9'd0}) + gps_pkg::KSTEP_W'({sched_q, 6'd0});
	end

	// Shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			gps_pkg::MUL_PROP: begin
				mul_a = gps_pkg::MA_W'(e_q);
				mul_b = gps_pkg::MB_W'(gain_prop_q);
			end
			gps_pkg::MUL_EAE: begin
				mul_a = gps_pkg::MA_W'(e_q);
				mul_b = $signed(gps_pkg::MB_W'(ae));
			end
			gps_pkg::MUL_QUAD: begin
				mul_a = prod_q[gps_pkg::MA_W-1:0];
				mul_b = gps_pkg::MB_W'(gain_quad_q);
			end
			default: begin
				mul_a = gps_pkg::MA_W'(diff_q);
				mul_b = kd_q;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Saturate and floor to Q8.8
	always_comb begin
		if (acc_q >= gps_pkg::ACC_W'(gps_pkg::SUM_LIMIT)) begin
			steer = gps_pkg::OUT_W'(gps_pkg::OUT_LIMIT);
		end else if (acc_q <= -gps_pkg::ACC_W'(gps_pkg::SUM_LIMIT)) begin
			steer = -gps_pkg::OUT_W'(gps_pkg::OUT_LIMIT);
		end else begin
			steer = acc_q[gps_pkg::OUT_W+7:8];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			e_q    <= pos_error;
			spd_q  <= avg_speed;
			diff_q <= gps_pkg::DIFF_W'(pos_error) - gps_pkg::DIFF_W'(prev_error_q);
		end
		sched_q <= sched;
		kd_q    <= gps_pkg::KD_W'(gain_deriv_q) + $signed(gps_pkg::KD_W'(kstep));
		prod_q  <= mul_p;
		case (cmd.acc_op)
			gps_pkg::ACC_LOAD: acc_q <= gps_pkg::ACC_W'(prod_q);
			gps_pkg::ACC_ADD:  acc_q <= acc_q + gps_pkg::ACC_W'(prod_q);
			default: ;
		endcase
		if (cmd.load_out) begin
			steer_q <= steer;
		end
	end

	assign steer_out = steer_q;

endmodule

// File: rtl/gps_ctrl.sv
// ----------------------------------------------------------------------------
// gps_ctrl
// Controller: sequences the shared multiplier and accumulator over one item
// and owns both handshakes.
// ----------------------------------------------------------------------------
module gps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output gps_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROP,
		ST_EAE,
		ST_QUAD,
		ST_DERIV,
		ST_SUM,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// A product lands in prod_q; the next step folds it into acc (EAE's goes to QUAD)
	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = gps_pkg::MUL_PROP;
		cmd.acc_op   = gps_pkg::ACC_HOLD;
		unique case (state_q)
			ST_IDLE:  cmd.load_in = in_valid;
			ST_PROP:  cmd.mul_sel = gps_pkg::MUL_PROP;
			ST_EAE: begin
				cmd.mul_sel = gps_pkg::MUL_EAE;
				cmd.acc_op  = gps_pkg::ACC_LOAD;
			end
			ST_QUAD:  cmd.mul_sel = gps_pkg::MUL_QUAD;
			ST_DERIV: begin
				cmd.mul_sel = gps_pkg::MUL_DERIV;
				cmd.acc_op  = gps_pkg::ACC_ADD;
			end
			ST_SUM:   cmd.acc_op = gps_pkg::ACC_ADD;
			ST_OUT:   cmd.load_out = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_PROP;
				ST_PROP:  state_q <= ST_EAE;
				ST_EAE:   state_q <= ST_QUAD;
				ST_QUAD:  state_q <= ST_DERIV;
				ST_DERIV: state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_OUT;
				ST_OUT: begin
					// hold until the output register is free
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=>
			!in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("new item taken during computation");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result shown outside the output step");

endmodule

// File: rtl/gain_scheduled_pd_steering.sv
// ----------------------------------------------------------------------------
// gain_scheduled_pd_steering
// Gain-scheduled PD steering controller: proportional, err*|err| and
// speed-scheduled derivative terms, saturated to +-100.0 in Q8.8.
// ----------------------------------------------------------------------------
//  channel  | signals                           | transfer when
//  ---------+-----------------------------------+----------------------------
//  input    | pos_error, avg_speed              | in_valid & in_ready
//  output   | steer_out                         | out_valid & out_ready
//  config   | cfg_index, cfg_data               | cfg_we (no wait)
//
//  An item passes from transfer to result load through an accept step and
//  six steps through the single shared 23x33 multiplier and accumulator.
//  A finished result waits in the output register; the next item is taken
//  while it waits, and the output step stalls only if the old result is
//  still there. Reset clears the gains and the previous error to zero.
// ----------------------------------------------------------------------------
module gain_scheduled_pd_steering (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gps_pkg::IDX_W-1:0]         cfg_index,
	input  logic [gps_pkg::GAIN_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [gps_pkg::ERR_W-1:0]  pos_error,
	input  logic signed [gps_pkg::SPD_W-1:0]  avg_speed,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [gps_pkg::OUT_W-1:0]  steer_out
);

	gps_pkg::dp_cmd_t cmd;

	gps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	gps_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pos_error (pos_error),
		.avg_speed (avg_speed),
		.cmd       (cmd),
		.steer_out (steer_out)
	);

endmodule
